// ----- rtl/offset_search_scroll_target_unit_defines.svh -----
// Assertion macros shared by the scroll target unit.
// No dependencies.
`ifndef OFFSET_SEARCH_SCROLL_TARGET_UNIT_DEFINES_SVH
`define OFFSET_SEARCH_SCROLL_TARGET_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OSST_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define OSST_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define OSST_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define OSST_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/osst_pkg.sv -----
// Package of the scroll target unit: codes, constants and state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package osst_pkg;
    localparam logic [31:0] UNSET_OFFSET = 32'hFFFF_FFFF;
    localparam logic [16:0] FRAC_ONE = 17'h1_0000;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_LAYOUT_COUNT = 2'd1;
    localparam logic [1:0] CFG_CONTENT_LENGTH = 2'd2;
    localparam logic [1:0] CFG_VIEWPORT_HEIGHT = 2'd3;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PROBE_CHK,
        ST_LEFT_CHK,
        ST_NODE_RD,
        ST_NODE_CHK,
        ST_WALK_CHK,
        ST_DIV,
        ST_MUL,
        ST_FINISH,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/osst_if.sv -----
// Valid/ready channel interfaces for requests and results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface osst_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic [9:0] entry_index;
    logic [31:0] entry_offset;
    logic [31:0] entry_top;
    logic [31:0] entry_extent;
    logic [31:0] change_position;
    logic [31:0] fallback_position;
    modport source (output valid, req_type, entry_index, entry_offset, entry_top,
        entry_extent, change_position, fallback_position, input ready);
    modport sink (input valid, req_type, entry_index, entry_offset, entry_top,
        entry_extent, change_position, fallback_position, output ready);
endinterface

interface osst_res_if;
    logic valid;
    logic ready;
    logic [31:0] scroll_target;
    logic used_fallback;
    modport source (output valid, scroll_target, used_fallback, input ready);
    modport sink (input valid, scroll_target, used_fallback, output ready);
endinterface
`default_nettype wire

// ----- rtl/osst_divider.sv -----
// Restoring serial divider giving floor((d << 16) / s) clamped to 1.0.
// Depends on osst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module osst_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [16:0]      frac
);
    logic [48:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [47:0] num_reg, num_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [48:0] shifted;
    logic [47:0] quo_full;
    logic [16:0] frac_reg, frac_next;
    logic        done_reg;

    // One quotient bit per cycle over the 48-bit numerator.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        num_next = num_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        shifted = {rem_reg[47:0], num_reg[47]};
        if (start)
        begin
            rem_next = '0;
            quo_next = '0;
            num_next = {dividend, 16'd0};
            div_next = divisor;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[46:0], 1'b0};
            if (shifted >= {17'd0, div_reg})
            begin
                rem_next = shifted - {17'd0, div_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
        div_reg <= div_next;
        if (busy_reg && (cnt_reg == 6'd1))
        begin
            frac_reg <= frac_next;
        end
    end

    // Clamp on the final quotient including the last bit; the result is registered.
    assign quo_full = {quo_reg[46:0], (shifted >= {17'd0, div_reg})};
    always_comb
    begin
        if (quo_full > {31'd0, osst_pkg::FRAC_ONE})
        begin
            frac_next = osst_pkg::FRAC_ONE;
        end
        else
        begin
            frac_next = quo_full[16:0];
        end
    end

    assign done = done_reg;
    assign frac = frac_reg;
endmodule
`default_nettype wire

// ----- rtl/offset_search_scroll_target_unit.sv -----
// Top level of the scroll target unit: node memory, search sequencer, output.
// Depends on osst_pkg, osst_if, osst_divider and the assertion header.
// A load writes one node entry when accepted. A query runs a binary search over
// the node table through the single read port, with a leftward scan past unset
// entries and a forward walk for the next offset, each one entry per cycle;
// then a serial divider with a registered result and a multiply. A query that
// returns the fallback skips the divider. The result waits in an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "offset_search_scroll_target_unit_defines.svh"
module offset_search_scroll_target_unit #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    osst_req_if.sink         req,
    osst_res_if.source       res,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = (AW + 2 > 12) ? AW + 2 : 12;

    osst_pkg::state_t state_reg, state_next;
    logic [10:0] entry_total_reg, layout_count_reg;
    logic [31:0] content_length_reg, viewport_height_reg;

    logic [95:0] mem [MAX_NODES];
    logic [95:0] rd_data;
    logic        mem_we;
    logic [AW-1:0] wr_addr, rd_addr;

    logic [31:0] pos_reg, fb_reg, start_reg, next_reg, top_reg, ext_reg;
    logic signed [CW-1:0] lo_reg, hi_reg, mid_reg, p_reg, found_reg, i_reg;
    logic signed [CW-1:0] lo_next, hi_next, mid_next, p_next, found_next, i_next;
    logic [31:0] start_next, next_next, top_next, ext_next;
    logic [31:0] out_val_reg, out_val_next;
    logic        out_fb_reg, out_fb_next;
    logic [63:0] prod_reg;
    logic        div_start, div_done;
    logic [16:0] frac;
    logic signed [CW-1:0] used_n;
    logic [31:0] rd_off;
    logic [63:0] margin_prod;
    logic [31:0] margin_reg;
    logic        res_stall;

    assign used_n = (32'(entry_total_reg) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
        : CW'(entry_total_reg);
    assign rd_off = rd_data[95:64];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg <= '0;
            layout_count_reg <= '0;
            content_length_reg <= '0;
            viewport_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                osst_pkg::CFG_NODE_COUNT:      entry_total_reg <= cfg_wdata[10:0];
                osst_pkg::CFG_LAYOUT_COUNT:    layout_count_reg <= cfg_wdata[10:0];
                osst_pkg::CFG_CONTENT_LENGTH:  content_length_reg <= cfg_wdata;
                osst_pkg::CFG_VIEWPORT_HEIGHT: viewport_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A fifth of the viewport height by reciprocal multiplication, kept in a register.
    assign margin_prod = {32'd0, viewport_height_reg} * 64'd3435973837;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= '0;
        end
        else
        begin
            margin_reg <= {2'b00, margin_prod[63:34]};
        end
    end

    // Node memory: offset, top and extent in one word.
    assign mem_we = req.valid && req.ready && (req.req_type == osst_pkg::REQ_LOAD)
        && ({22'd0, req.entry_index} < 32'(MAX_NODES));
    assign wr_addr = AW'(req.entry_index);
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {req.entry_offset, req.entry_top, req.entry_extent};
        end
        rd_data <= mem[rd_addr];
    end

    assign req.ready = (state_reg == osst_pkg::ST_IDLE);

    // Next state and datapath updates of the search sequencer.
    always_comb
    begin
        state_next = state_reg;
        lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg; p_next = p_reg;
        found_next = found_reg; i_next = i_reg;
        start_next = start_reg; next_next = next_reg;
        top_next = top_reg; ext_next = ext_reg;
        out_val_next = out_val_reg; out_fb_next = out_fb_reg;
        div_start = 1'b0;
        rd_addr = AW'(mid_reg);
        case (state_reg)
            osst_pkg::ST_IDLE:
            begin
                if (req.valid && req.req_type == osst_pkg::REQ_QUERY)
                begin
                    lo_next = '0;
                    hi_next = used_n - CW'(1);
                    found_next = -CW'(1);
                    state_next = osst_pkg::ST_PROBE;
                end
            end
            osst_pkg::ST_PROBE:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mid_next = lo_reg + ((hi_reg - lo_reg) >>> 1);
                    rd_addr = AW'(mid_next);
                    state_next = osst_pkg::ST_PROBE_CHK;
                end
                else
                begin
                    state_next = osst_pkg::ST_NODE_RD;
                end
            end
            osst_pkg::ST_PROBE_CHK:
            begin
                if (rd_off == osst_pkg::UNSET_OFFSET)
                begin
                    p_next = mid_reg - CW'(1);
                    if (p_next < lo_reg)
                    begin
                        lo_next = mid_reg + CW'(1);
                        state_next = osst_pkg::ST_PROBE;
                    end
                    else
                    begin
                        rd_addr = AW'(p_next);
                        state_next = osst_pkg::ST_LEFT_CHK;
                    end
                end
                else if (rd_off <= pos_reg)
                begin
                    found_next = mid_reg;
                    lo_next = mid_reg + CW'(1);
                    state_next = osst_pkg::ST_PROBE;
                end
                else
                begin
                    hi_next = mid_reg - CW'(1);
                    state_next = osst_pkg::ST_PROBE;
                end
            end
            osst_pkg::ST_LEFT_CHK:
            begin
                if (rd_off == osst_pkg::UNSET_OFFSET)
                begin
                    p_next = p_reg - CW'(1);
                    if (p_next < lo_reg)
                    begin
                        lo_next = mid_reg + CW'(1);
                        state_next = osst_pkg::ST_PROBE;
                    end
                    else
                    begin
                        rd_addr = AW'(p_next);
                    end
                end
                else if (rd_off <= pos_reg)
                begin
                    found_next = p_reg;
                    lo_next = mid_reg + CW'(1);
                    state_next = osst_pkg::ST_PROBE;
                end
                else
                begin
                    hi_next = p_reg - CW'(1);
                    state_next = osst_pkg::ST_PROBE;
                end
            end
            osst_pkg::ST_NODE_RD:
            begin
                if (found_reg < 0 || found_reg >= CW'(layout_count_reg))
                begin
                    out_val_next = fb_reg;
                    out_fb_next = 1'b1;
                    state_next = osst_pkg::ST_OUT;
                end
                else
                begin
                    rd_addr = AW'(found_reg);
                    state_next = osst_pkg::ST_NODE_CHK;
                end
            end
            osst_pkg::ST_NODE_CHK:
            begin
                start_next = rd_data[95:64];
                top_next = rd_data[63:32];
                ext_next = rd_data[31:0];
                next_next = content_length_reg;
                i_next = found_reg + CW'(1);
                if (i_next < used_n)
                begin
                    rd_addr = AW'(i_next);
                    state_next = osst_pkg::ST_WALK_CHK;
                end
                else
                begin
                    state_next = osst_pkg::ST_DIV;
                end
            end
            osst_pkg::ST_WALK_CHK:
            begin
                if (rd_off != osst_pkg::UNSET_OFFSET && rd_off > start_reg)
                begin
                    next_next = rd_off;
                    state_next = osst_pkg::ST_DIV;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    if (i_next < used_n)
                    begin
                        rd_addr = AW'(i_next);
                    end
                    else
                    begin
                        state_next = osst_pkg::ST_DIV;
                    end
                end
            end
            osst_pkg::ST_DIV:
            begin
                if (next_reg > start_reg)
                begin
                    div_start = 1'b1;
                    state_next = osst_pkg::ST_MUL;
                end
                else
                begin
                    ext_next = '0;
                    state_next = osst_pkg::ST_FINISH;
                end
            end
            osst_pkg::ST_MUL:
            begin
                if (div_done)
                begin
                    state_next = osst_pkg::ST_FINISH;
                end
            end
            osst_pkg::ST_FINISH:
            begin
                out_fb_next = 1'b0;
                state_next = osst_pkg::ST_OUT;
            end
            osst_pkg::ST_OUT:
            begin
                if (res.ready)
                begin
                    state_next = osst_pkg::ST_IDLE;
                end
            end
            default: state_next = osst_pkg::ST_IDLE;
        endcase
    end

    // Interpolated top, saturated, then margin removed.
    logic [32:0] y_sum;
    logic [31:0] y_sat;
    assign y_sum = {1'b0, top_reg} + {1'b0, prod_reg[47:16]};
    assign y_sat = (y_sum[32] || prod_reg[63:48] != 16'd0) ? 32'hFFFF_FFFF : y_sum[31:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == osst_pkg::ST_IDLE)
        begin
            pos_reg <= req.change_position;
            fb_reg <= req.fallback_position;
            prod_reg <= '0;
        end
        else if (state_reg == osst_pkg::ST_MUL && div_done)
        begin
            prod_reg <= {32'd0, ext_reg} * {47'd0, frac};
        end
        lo_reg <= lo_next; hi_reg <= hi_next; mid_reg <= mid_next; p_reg <= p_next;
        found_reg <= found_next; i_reg <= i_next;
        start_reg <= start_next; next_reg <= next_next;
        top_reg <= top_next; ext_reg <= ext_next;
        if (state_reg == osst_pkg::ST_FINISH)
        begin
            out_val_reg <= (y_sat > margin_reg) ? (y_sat - margin_reg) : 32'd0;
        end
        else
        begin
            out_val_reg <= out_val_next;
        end
        out_fb_reg <= out_fb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= osst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    osst_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pos_reg - start_reg),
        .divisor  (next_reg - start_reg),
        .done     (div_done),
        .frac     (frac)
    );

    assign res.valid = (state_reg == osst_pkg::ST_OUT);
    assign res.scroll_target = out_val_reg;
    assign res.used_fallback = out_fb_reg;
    assign res_stall = res.valid && !res.ready;

    `OSST_ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, res.valid, !req.ready)
    `OSST_ASSERT_NEXT(a_out_hold, clk, rst_n, res_stall, res.valid && $stable(res.scroll_target))
    `OSST_ASSERT_IMPLIES(a_div_only_mul, clk, rst_n, div_done, state_reg == osst_pkg::ST_MUL)
endmodule
`default_nettype wire
